// ===== rtl/key_debounce_long_press_classifier_defines.svh =====
// Assertion macros of the key debounce and long-press classifier RTL, used by kdlp_fsm.
`ifndef KEY_DEBOUNCE_LONG_PRESS_CLASSIFIER_DEFINES_SVH
`define KEY_DEBOUNCE_LONG_PRESS_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define KDLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define KDLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/kdlp_pkg.sv =====
// Types and constants of the key debounce and long-press classifier.
package kdlp_pkg;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_DEBOUNCE = 5'b00010,
    PH_DIR_HOLD = 5'b00100,
    PH_TOP_TIME = 5'b01000,
    PH_TOP_HOLD = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] debounce_ticks;
    logic [9:0] unit_ticks;
    logic [3:0] limit_units;
    logic [3:0] short_max_units;
  } cfg_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_DEBOUNCE_TICKS  = 2'd0;
  localparam logic [1:0] REG_UNIT_TICKS      = 2'd1;
  localparam logic [1:0] REG_LIMIT_UNITS     = 2'd2;
  localparam logic [1:0] REG_SHORT_MAX_UNITS = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [7:0] RST_DEBOUNCE_TICKS  = 8'd30;
  localparam logic [9:0] RST_UNIT_TICKS      = 10'd100;
  localparam logic [3:0] RST_LIMIT_UNITS     = 4'd12;
  localparam logic [3:0] RST_SHORT_MAX_UNITS = 4'd5;

  // Bit positions of the keys in the pressed-key vector.
  localparam logic [2:0] BIT_LEFT  = 3'd0;
  localparam logic [2:0] BIT_UP    = 3'd1;
  localparam logic [2:0] BIT_RIGHT = 3'd2;
  localparam logic [2:0] BIT_DOWN  = 3'd3;
  localparam logic [2:0] BIT_LTOP  = 3'd4;
  localparam logic [2:0] BIT_RTOP  = 3'd5;

  // Event codes.
  localparam logic [2:0] EV_LEFT      = 3'd0;
  localparam logic [2:0] EV_RIGHT     = 3'd1;
  localparam logic [2:0] EV_UP        = 3'd2;
  localparam logic [2:0] EV_DOWN      = 3'd3;
  localparam logic [2:0] EV_LTOP      = 3'd4;
  localparam logic [2:0] EV_LTOP_LONG = 3'd5;
  localparam logic [2:0] EV_RTOP      = 3'd6;
  localparam logic [2:0] EV_RTOP_LONG = 3'd7;

  localparam logic [9:0] TICK_MAX = 10'h3FF;

endpackage

// ===== rtl/kdlp_fsm.sv =====
// Debounce, key selection and hold-timing state machine, one tick per step.
`include "key_debounce_long_press_classifier_defines.svh"

module kdlp_fsm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [5:0]        pressed_keys,
  input  kdlp_pkg::cfg_t    cfg,
  output logic              emit,
  output logic [2:0]        key_event
);
  import kdlp_pkg::*;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] unit_count;
    logic [9:0] tick_count;
    logic       emit;
    logic [2:0] ev;
  } sample_t;

  phase_t     phase_r, phase_nxt;
  logic [9:0] tick_count_r, tick_count_nxt;
  logic [3:0] unit_count_r, unit_count_nxt;
  logic [2:0] held_key_r, held_key_nxt;
  logic       down;
  logic [9:0] tick_inc;
  sample_t    smp;

  // Unit boundary of a top key: keep timing, report, or wait for release.
  function automatic sample_t top_sample(input logic down_i, input logic [3:0] units,
                                         input logic [9:0] ticks, input logic [2:0] key,
                                         input cfg_t c);
    sample_t s;
    s.phase      = PH_IDLE;
    s.unit_count = units;
    s.tick_count = ticks;
    s.emit       = 1'b0;
    s.ev         = EV_LEFT;
    if (down_i && (units < c.limit_units)) begin
      s.unit_count = units + 4'd1;
      s.tick_count = '0;
      s.phase      = PH_TOP_TIME;
    end else if (units <= c.short_max_units) begin
      s.emit = 1'b1;
      s.ev   = (key == BIT_LTOP) ? EV_LTOP : EV_RTOP;
    end else if (!down_i) begin
      s.emit = 1'b1;
      s.ev   = (key == BIT_LTOP) ? EV_LTOP_LONG : EV_RTOP_LONG;
    end else begin
      s.phase = PH_TOP_HOLD;
    end
    return s;
  endfunction

  assign down     = pressed_keys[held_key_r];
  assign tick_inc = (tick_count_r == TICK_MAX) ? tick_count_r : tick_count_r + 10'd1;

  always_comb begin
    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    unit_count_nxt = unit_count_r;
    held_key_nxt   = held_key_r;
    emit           = 1'b0;
    key_event      = EV_LEFT;
    smp            = '0;
    case (phase_r)
      PH_IDLE: begin
        if (pressed_keys != '0) begin
          phase_nxt      = PH_DEBOUNCE;
          tick_count_nxt = '0;
        end
      end
      PH_DEBOUNCE: begin
        tick_count_nxt = tick_inc;
        if (tick_inc >= {2'b00, cfg.debounce_ticks}) begin
          tick_count_nxt = '0;
          if (pressed_keys[BIT_LEFT]) begin
            held_key_nxt = BIT_LEFT;
            phase_nxt    = PH_DIR_HOLD;
          end else if (pressed_keys[BIT_RIGHT]) begin
            held_key_nxt = BIT_RIGHT;
            phase_nxt    = PH_DIR_HOLD;
          end else if (pressed_keys[BIT_UP]) begin
            held_key_nxt = BIT_UP;
            phase_nxt    = PH_DIR_HOLD;
          end else if (pressed_keys[BIT_DOWN]) begin
            held_key_nxt = BIT_DOWN;
            phase_nxt    = PH_DIR_HOLD;
          end else if (pressed_keys[BIT_LTOP] || pressed_keys[BIT_RTOP]) begin
            held_key_nxt   = pressed_keys[BIT_LTOP] ? BIT_LTOP : BIT_RTOP;
            smp            = top_sample(1'b1, 4'd0, '0, held_key_nxt, cfg);
            phase_nxt      = smp.phase;
            unit_count_nxt = smp.unit_count;
            tick_count_nxt = smp.tick_count;
            emit           = smp.emit;
            key_event      = smp.ev;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_DIR_HOLD: begin
        if (!down) begin
          emit      = 1'b1;
          phase_nxt = PH_IDLE;
          case (held_key_r)
            BIT_UP:    key_event = EV_UP;
            BIT_RIGHT: key_event = EV_RIGHT;
            BIT_DOWN:  key_event = EV_DOWN;
            default:   key_event = EV_LEFT;
          endcase
        end
      end
      PH_TOP_TIME: begin
        tick_count_nxt = tick_inc;
        if (tick_inc >= cfg.unit_ticks) begin
          smp            = top_sample(down, unit_count_r, tick_inc, held_key_r, cfg);
          phase_nxt      = smp.phase;
          unit_count_nxt = smp.unit_count;
          tick_count_nxt = smp.tick_count;
          emit           = smp.emit;
          key_event      = smp.ev;
        end
      end
      PH_TOP_HOLD: begin
        if (!down) begin
          emit      = 1'b1;
          phase_nxt = PH_IDLE;
          key_event = (held_key_r == BIT_LTOP) ? EV_LTOP_LONG : EV_RTOP_LONG;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tick_count_r <= '0;
      unit_count_r <= '0;
      held_key_r   <= BIT_LEFT;
    end else if (step) begin
      phase_r      <= phase_nxt;
      tick_count_r <= tick_count_nxt;
      unit_count_r <= unit_count_nxt;
      held_key_r   <= held_key_nxt;
    end
  end

  `KDLP_ASSERT_NOW(a_idle_no_event, step && (phase_r == PH_IDLE), !emit,
                   "event reported from idle")
  `KDLP_ASSERT_NEXT(a_event_ends_in_idle, step && emit, phase_r == PH_IDLE,
                    "event did not return to idle")
  `KDLP_ASSERT_NEXT(a_press_starts_debounce,
                    step && (phase_r == PH_IDLE) && (pressed_keys != '0),
                    (phase_r == PH_DEBOUNCE) && (tick_count_r == '0),
                    "press did not start debounce")

endmodule

// ===== rtl/key_debounce_long_press_classifier.sv =====
// Top level of the key debounce and long-press classifier.
//
//   channel  direction  signals                      transaction
//   in       input      in_valid/in_ready            one tick of six key levels
//   out      output     out_valid/out_ready          one key event code
//   cfg      input      cfg_we/cfg_index/cfg_wdata   one register write
//
// A new tick may follow in every cycle while no event waits on a low out_ready.
// The state update and event decode sit between the state registers and the
// output register, so an event appears in the cycle after its tick is accepted.
// A pending event stalls input only while out_ready is low.
// Synchronous active-low reset returns the machine to idle with the default
// timing registers and an empty output register.
module key_debounce_long_press_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [5:0] in_pressed_keys,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_key_event,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_wdata
);
  import kdlp_pkg::*;

  cfg_t       cfg_r;
  logic       out_valid_r;
  logic [2:0] out_key_event_r;
  logic       in_fire;
  logic       emit;
  logic [2:0] key_event;

  assign in_ready      = !out_valid_r || out_ready;
  assign in_fire       = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_key_event = out_key_event_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks  <= RST_DEBOUNCE_TICKS;
      cfg_r.unit_ticks      <= RST_UNIT_TICKS;
      cfg_r.limit_units     <= RST_LIMIT_UNITS;
      cfg_r.short_max_units <= RST_SHORT_MAX_UNITS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE_TICKS:  cfg_r.debounce_ticks  <= cfg_wdata[7:0];
        REG_UNIT_TICKS:      cfg_r.unit_ticks      <= cfg_wdata;
        REG_LIMIT_UNITS:     cfg_r.limit_units     <= cfg_wdata[3:0];
        REG_SHORT_MAX_UNITS: cfg_r.short_max_units <= cfg_wdata[3:0];
        default:             cfg_r                 <= cfg_r;
      endcase
    end
  end

  kdlp_fsm u_fsm (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_fire),
    .pressed_keys (in_pressed_keys),
    .cfg          (cfg_r),
    .emit         (emit),
    .key_event    (key_event)
  );

  // An accepted tick replaces the output; the old event has left when it does.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_key_event_r <= key_event;
    end
  end

endmodule
